>>> rtl/dasrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dasrm_pkg: shared types and constants of the dual-converter SPI master
// Command and result formats, opcodes, frame kinds and status codes.
// ----------------------------------------------------------------------------
package dasrm_pkg;

  // Field widths
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned ADDR_W   = 15;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned FRAME_W  = 24;
  localparam int unsigned COUNT_W  = 5;

  // Frame timing: address phase length and last bit of a frame
  localparam logic [COUNT_W-1:0] ADDR_BITS     = 5'd16;
  localparam logic [COUNT_W-1:0] FRAME_LAST    = 5'd23;

  // Default queue depths
  localparam int unsigned CMD_QUEUE_DEPTH = 4;
  localparam int unsigned RES_QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ0 = 2'd1,
    OP_READ1 = 2'd2,
    OP_TICK  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ0 = 2'd1,
    KIND_READ1 = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BUSY = 2'd1,
    STATUS_IDLE = 2'd2
  } status_e;

  // Classified command handed from front to back
  typedef struct packed {
    logic               is_tick;
    kind_e              kind;
    logic [FRAME_W-1:0] frame;
    logic               miso0;
    logic               miso1;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic              mosi;
    logic              sel0_n;
    logic              sel1_n;
    logic              clk_pulse;
    logic [DATA_W-1:0] rd_byte;
    logic              done;
    status_e           status;
  } res_t;

  localparam int unsigned CMD_W = $bits(cmd_t);
  localparam int unsigned RES_W = $bits(res_t);

  // Active-low selects {dev0, dev1} for a given frame state
  function automatic logic [1:0] selects(input logic busy, input kind_e kind);
    logic [1:0] sel;
    sel = 2'b11;
    if (busy) begin
      case (kind)
        KIND_WRITE: sel = 2'b00;
        KIND_READ0: sel = 2'b01;
        KIND_READ1: sel = 2'b10;
        default:    sel = 2'b11;
      endcase
    end
    return sel;
  endfunction

endpackage
`default_nettype wire

>>> rtl/dasrm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dasrm_fifo: small register-based queue
// Flop storage with read and write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module dasrm_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dasrm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dasrm_front: command classifier
// Decodes the opcode into a tick or a frame kind and builds the 24-bit frame.
// ----------------------------------------------------------------------------
module dasrm_front
  import dasrm_pkg::*;
(
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [ADDR_W-1:0]   reg_address_i,
  input  wire logic [DATA_W-1:0]   write_byte_i,
  input  wire logic                miso_dev0_i,
  input  wire logic                miso_dev1_i,
  output cmd_t                     cmd_o
);

  // Classify and assemble the frame
  always_comb begin
    cmd_o.is_tick = 1'b0;
    cmd_o.kind    = KIND_WRITE;
    cmd_o.frame   = {1'b0, reg_address_i, write_byte_i};
    cmd_o.miso0   = miso_dev0_i;
    cmd_o.miso1   = miso_dev1_i;
    case (opcode_e'(opcode_i))
      OP_WRITE: begin
        cmd_o.kind  = KIND_WRITE;
      end
      OP_READ0: begin
        cmd_o.kind  = KIND_READ0;
        cmd_o.frame = {1'b1, reg_address_i, {DATA_W{1'b0}}};
      end
      OP_READ1: begin
        cmd_o.kind  = KIND_READ1;
        cmd_o.frame = {1'b1, reg_address_i, {DATA_W{1'b0}}};
      end
      OP_TICK: begin
        cmd_o.is_tick = 1'b1;
      end
      default: begin
        cmd_o.is_tick = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/dasrm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dasrm_back: frame engine
// Holds the frame state, shifts one bit per tick and produces one result
// beat for every command it takes.
// ----------------------------------------------------------------------------
module dasrm_back
  import dasrm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  wire logic res_ready_i,
  output logic      res_push_o,
  output res_t      res_o
);

  logic [FRAME_W-1:0] shift_q, shift_d;
  logic [COUNT_W-1:0] count_q, count_d;
  kind_e              kind_q, kind_d;
  logic               busy_q, busy_d;
  logic [DATA_W-1:0]  in_q, in_d;
  logic               mosi_q, mosi_d;
  logic               fire;
  logic [1:0]         sel;

  assign fire       = cmd_valid_i && res_ready_i;
  assign cmd_pop_o  = fire;
  assign res_push_o = fire;

  // Execute one command
  always_comb begin
    shift_d = shift_q;
    count_d = count_q;
    kind_d  = kind_q;
    busy_d  = busy_q;
    in_d    = in_q;
    mosi_d  = mosi_q;
    sel     = selects(busy_q, kind_q);

    res_o.mosi      = mosi_q;
    res_o.clk_pulse = 1'b0;
    res_o.rd_byte   = '0;
    res_o.done      = 1'b0;
    res_o.status    = STATUS_OK;

    if (fire) begin
      if (!cmd_i.is_tick) begin
        if (busy_q) begin
          res_o.status = STATUS_BUSY;
        end else begin
          busy_d  = 1'b1;
          count_d = '0;
          in_d    = '0;
          kind_d  = cmd_i.kind;
          shift_d = cmd_i.frame;
          sel     = selects(1'b1, cmd_i.kind);
        end
      end else if (!busy_q) begin
        res_o.status = STATUS_IDLE;
      end else begin
        res_o.clk_pulse = 1'b1;
        // Shift out during the address or write phase, sample otherwise
        if (kind_q == KIND_WRITE || count_q < ADDR_BITS) begin
          mosi_d  = shift_q[FRAME_W-1];
          shift_d = {shift_q[FRAME_W-2:0], 1'b0};
        end else begin
          in_d = {in_q[DATA_W-2:0], (kind_q == KIND_READ1) ? cmd_i.miso1 : cmd_i.miso0};
        end
        res_o.mosi = mosi_d;
        count_d    = count_q + 1'b1;
        // Close the frame on its last bit
        if (count_q == FRAME_LAST) begin
          res_o.done    = 1'b1;
          res_o.rd_byte = (kind_q != KIND_WRITE) ? in_d : '0;
          busy_d        = 1'b0;
          count_d       = '0;
        end
      end
    end
    res_o.sel0_n = sel[1];
    res_o.sel1_n = sel[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      count_q <= '0;
      kind_q  <= KIND_WRITE;
      busy_q  <= 1'b0;
      in_q    <= '0;
      mosi_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      count_q <= count_d;
      kind_q  <= kind_d;
      busy_q  <= busy_d;
      in_q    <= in_d;
      mosi_q  <= mosi_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/dual_adc_spi_register_master_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dual_adc_spi_register_master_top: SPI register master for two converters
// Write frames go to both devices, read frames to one; ticks clock the bits.
// ----------------------------------------------------------------------------
// Items are accepted one per clock while the command queue is not full, and
// one result comes back for each item, in order. An accepted item lands in
// the command queue; the frame engine takes it from there and writes its
// result into the result queue, from which it shows on the outputs and can
// be popped. Throughput is set by the frame engine, which takes one command
// per cycle while the result queue is not full; full rises only when the
// result side stalls long enough to fill both queues. No clearing pass after
// reset.
module dual_adc_spi_register_master_top
  import dasrm_pkg::*;
#(
  parameter int unsigned CmdDepth = CMD_QUEUE_DEPTH,
  parameter int unsigned ResDepth = RES_QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [OPCODE_W-1:0] opcode_i,
  input  wire logic [ADDR_W-1:0]   reg_address_i,
  input  wire logic [DATA_W-1:0]   write_byte_i,
  input  wire logic                miso_dev0_i,
  input  wire logic                miso_dev1_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     mosi_level_o,
  output logic                     select0_n_o,
  output logic                     select1_n_o,
  output logic                     clock_pulse_o,
  output logic [DATA_W-1:0]        read_byte_o,
  output logic                     frame_done_o,
  output logic [1:0]               status_o
);

  cmd_t cmd_in, cmd_out;
  res_t res_in, res_out;
  logic cmd_empty, cmd_pop;
  logic res_full, res_push;

  // Classify incoming items
  dasrm_front u_front (
    .opcode_i      (opcode_i),
    .reg_address_i (reg_address_i),
    .write_byte_i  (write_byte_i),
    .miso_dev0_i   (miso_dev0_i),
    .miso_dev1_i   (miso_dev1_i),
    .cmd_o         (cmd_in)
  );

  // Decouple front from frame engine
  dasrm_fifo #(
    .Width (CMD_W),
    .Depth (CmdDepth)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  // Run frames
  dasrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_ready_i (!res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Hold results until popped
  dasrm_fifo #(
    .Width (RES_W),
    .Depth (ResDepth)
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign mosi_level_o  = res_out.mosi;
  assign select0_n_o   = res_out.sel0_n;
  assign select1_n_o   = res_out.sel1_n;
  assign clock_pulse_o = res_out.clk_pulse;
  assign read_byte_o   = res_out.rd_byte;
  assign frame_done_o  = res_out.done;
  assign status_o      = res_out.status;

endmodule
`default_nettype wire

>>> rtl/dasrm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dasrm_checker: port-level checks of the SPI register master
// Relations between result fields and reset behavior seen on the ports.
// ----------------------------------------------------------------------------
module dasrm_checker
  import dasrm_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                select0_n_o,
  input wire logic                select1_n_o,
  input wire logic                clock_pulse_o,
  input wire logic [DATA_W-1:0]   read_byte_o,
  input wire logic                frame_done_o,
  input wire logic [1:0]          status_o
);

  // Nothing waits on the result side while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty during reset");

  // A clocked bit always reports ok status
  a_pulse_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && clock_pulse_o) |-> (status_o == STATUS_OK))
    else $error("clock pulse with error status");

  // A frame only completes on a clocked bit
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_done_o) |-> clock_pulse_o)
    else $error("frame done without clock pulse");

  // An idle tick leaves both devices deselected
  a_idle_desel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_IDLE) |-> (select0_n_o && select1_n_o))
    else $error("select low on idle tick");

  // Read data only appears at the end of a frame
  a_byte_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && read_byte_o != '0) |-> frame_done_o)
    else $error("read byte outside frame end");

endmodule

bind dual_adc_spi_register_master_top dasrm_checker u_dasrm_checker (.*);
`default_nettype wire
